[hw/rtl/rff_pkg.sv]
// shared constants and types for the replay freshness filter
package rff_pkg;

	// table geometry
	localparam int SENDERS = 16;
	localparam int SLOT_W  = (SENDERS > 1) ? $clog2(SENDERS) : 1;

	// field widths
	localparam int IDX_W    = 4;
	localparam int SEQ_W    = 32;
	localparam int TIME_W   = 63;
	localparam int GAP_W    = 32;
	localparam int REASON_W = 3;

	// packed stream widths, rounded up to whole bytes
	localparam int IN_BITS  = IDX_W + SEQ_W + TIME_W + TIME_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 1 + REASON_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(200000000);

	typedef enum logic [REASON_W-1:0] {
		R_FRESH   = 3'd0,
		R_OLD_SEQ = 3'd1,
		R_DUP_TS  = 3'd2,
		R_BURST   = 3'd3,
		R_OLD_TS  = 3'd4
	} reason_t;

	// one table entry as held in the memory
	typedef struct packed {
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] orig;
		logic [SEQ_W-1:0]  seq;
	} entry_t;

	// compare results carried from the read stage to the decision stage
	typedef struct packed {
		logic vld;
		logic seq_lt;
		logic seq_eq;
		logic orig_eq;
		logic orig_lt;
	} flags_t;

endpackage

[hw/rtl/replay_freshness_filter.sv]
// top level of the per-sender replay freshness filter
//
//  channel  | direction | handshake          | content
//  ---------+-----------+--------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | sender_index, sequence_req, orig/arrival ns
//  m_*      | out       | m_tvalid/m_tready  | accept, reason
//  cfg_*    | in        | cfg_we             | burst_gap_ns
//
// one message is in flight at a time; the edge that takes a beat also launches
// the table read, then the read stage compares and the decide stage decides and
// writes back, loading the output register that drives m_tvalid
// a new beat is taken only once the previous message has passed the memory read
// and the compare and decide stages
// the next message can be taken as soon as the previous one has reached the
// output register, even while that result still waits for m_tready
// a decided message holds in the decide stage while the output register is full
// reset clears the per-sender valid bits and the state; the table memory itself
// is never cleared, an entry's content only counts once its valid bit is set
// burst_gap_ns comes out of reset at 200 ms

module replay_freshness_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	// beat fields from bit 0: sender_index[3:0], sequence_req[35:4],
	// orig_time_ns[98:36], arrival_time_ns[161:99], zero fill
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rff_pkg::IN_W-1:0]    s_tdata,
	// beat fields from bit 0: accept[0], reason[3:1], zero fill
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rff_pkg::OUT_W-1:0]   m_tdata,
	// burst gap register
	input  logic                        cfg_we,
	input  logic [rff_pkg::GAP_W-1:0]   cfg_wdata
);

	localparam int SEQ_LO  = rff_pkg::IDX_W;
	localparam int ORIG_LO = SEQ_LO + rff_pkg::SEQ_W;
	localparam int ARR_LO  = ORIG_LO + rff_pkg::TIME_W;
	localparam int DIFF_W  = rff_pkg::TIME_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_JUDGE
	} state_t;

	state_t state_q;

	// unpacked input beat
	logic [rff_pkg::IDX_W-1:0]   in_idx;
	logic [rff_pkg::SLOT_W-1:0]  in_slot;
	rff_pkg::entry_t             in_entry;

	// request held for the duration of one message
	logic [rff_pkg::SLOT_W-1:0]  slot_q;
	rff_pkg::entry_t             req_q;

	// configuration
	logic [rff_pkg::GAP_W-1:0]   gap_q;

	// per-sender valid bits, in flops so reset clears them at once
	logic [rff_pkg::SENDERS-1:0] valid_q;

	// table memory, one read port, one write port, registered read
	rff_pkg::entry_t             mem [rff_pkg::SENDERS];
	rff_pkg::entry_t             rd_q;
	logic                        mem_re;
	logic                        mem_we;

	// read stage results
	rff_pkg::flags_t             flags_c;
	logic [DIFF_W-1:0]           diff_c;
	rff_pkg::flags_t             flags_s1;
	logic [DIFF_W-1:0]           diff_s1;

	// decide stage
	logic                        burst_c;
	rff_pkg::reason_t            reason_c;
	logic                        out_free;

	// output register
	logic                        m_valid_q;
	logic                        m_accept_q;
	rff_pkg::reason_t            m_reason_q;

	logic                        in_fire;

	// ---------------------------------------------------------------- input side
	assign in_idx            = s_tdata[rff_pkg::IDX_W-1:0];
	assign in_slot           = rff_pkg::SLOT_W'(32'(in_idx) % rff_pkg::SENDERS);
	assign in_entry.seq      = s_tdata[SEQ_LO +: rff_pkg::SEQ_W];
	assign in_entry.orig     = s_tdata[ORIG_LO +: rff_pkg::TIME_W];
	assign in_entry.arr      = s_tdata[ARR_LO +: rff_pkg::TIME_W];

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// ---------------------------------------------------------------- table memory
	// the read is launched with the accepted beat; the only write comes from the
	// decide stage of the same message, so read and write never overlap
	assign mem_re = in_fire;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_q] <= req_q;
		end
		if (mem_re) begin
			rd_q <= mem[in_slot];
		end
	end

	// ---------------------------------------------------------------- read stage
	// compares against the stored entry; arrival difference taken as signed 64 bit
	always_comb begin
		flags_c.vld     = valid_q[slot_q];
		flags_c.seq_lt  = req_q.seq < rd_q.seq;
		flags_c.seq_eq  = req_q.seq == rd_q.seq;
		flags_c.orig_eq = req_q.orig == rd_q.orig;
		flags_c.orig_lt = req_q.orig < rd_q.orig;
		diff_c          = {1'b0, req_q.arr} - {1'b0, rd_q.arr};
	end

	// ---------------------------------------------------------------- decide stage
	// first failing check wins, in the order of the reason codes
	assign burst_c = $signed(diff_s1) < $signed({{(DIFF_W-rff_pkg::GAP_W){1'b0}}, gap_q});

	always_comb begin
		if (!flags_s1.vld) begin
			reason_c = rff_pkg::R_FRESH;
		end else if (flags_s1.seq_lt) begin
			reason_c = rff_pkg::R_OLD_SEQ;
		end else if (flags_s1.seq_eq && flags_s1.orig_eq) begin
			reason_c = rff_pkg::R_DUP_TS;
		end else if (flags_s1.seq_eq && burst_c) begin
			reason_c = rff_pkg::R_BURST;
		end else if (flags_s1.orig_lt) begin
			reason_c = rff_pkg::R_OLD_TS;
		end else begin
			reason_c = rff_pkg::R_FRESH;
		end
	end

	assign out_free = !m_valid_q || m_tready;
	assign mem_we   = (state_q == ST_JUDGE) && out_free && (reason_c == rff_pkg::R_FRESH);

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			gap_q      <= rff_pkg::GAP_RESET;
			m_valid_q  <= 1'b0;
			m_accept_q <= 1'b0;
			m_reason_q <= rff_pkg::R_FRESH;
		end else begin
			if (cfg_we) begin
				gap_q <= cfg_wdata;
			end
			// result register: loaded by the decide stage, emptied by m_tready
			if ((state_q == ST_JUDGE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_JUDGE;
				end
				ST_JUDGE: begin
					if (out_free) begin
						m_accept_q <= (reason_c == rff_pkg::R_FRESH);
						m_reason_q <= reason_c;
						if (mem_we) begin
							valid_q[slot_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_q <= in_slot;
			req_q  <= in_entry;
		end
		if (state_q == ST_READ) begin
			flags_s1 <= flags_c;
			diff_s1  <= diff_c;
		end
	end

	// ---------------------------------------------------------------- output side
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(rff_pkg::OUT_W-rff_pkg::OUT_BITS){1'b0}}, m_reason_q, m_accept_q};

	// ---------------------------------------------------------------- assertions
	a_accept_matches_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_accept_q == (m_reason_q == rff_pkg::R_FRESH)))
		else $error("accept flag disagrees with reason code");

	a_write_only_when_decided: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_JUDGE) && out_free)
		else $error("table written outside the decide stage");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> valid_q[$past(slot_q)])
		else $error("valid bit not set after table write");

	a_beat_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_READ))
		else $error("accepted beat did not start a table read");

	a_reason_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_reason_q == rff_pkg::R_FRESH || m_reason_q == rff_pkg::R_OLD_SEQ ||
			m_reason_q == rff_pkg::R_DUP_TS || m_reason_q == rff_pkg::R_BURST ||
			m_reason_q == rff_pkg::R_OLD_TS))
		else $error("result reason code out of range");

endmodule

[tb/tb_replay_freshness_filter.sv]
// self-checking testbench for the replay freshness filter: directed table, then random traffic
module tb_replay_freshness_filter;
	timeunit 1ns;
	timeprecision 1ps;

	import rff_pkg::*;

	// no-progress limit: a result passes the read and decide stages after its beat,
	// and idle runs at 61 percent stay short, so this leaves a wide margin
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;
	localparam int SHOW_MAX    = 10;

	localparam logic [TIME_W-1:0] TMAX   = {TIME_W{1'b1}};
	localparam logic [SEQ_W-1:0]  SEQMAX = {SEQ_W{1'b1}};

	// one message as it travels on the slave side
	typedef struct packed {
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] orig;
		logic [SEQ_W-1:0]  seq;
		logic [IDX_W-1:0]  idx;
	} msg_t;

	// the verdict the block should give for one message
	typedef struct packed {
		logic    accept;
		reason_t reason;
	} verdict_t;

	// one row of the directed table; typed rows carry a hand-written verdict
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] orig;
		logic [TIME_W-1:0] arr;
		logic              typed;
		reason_t           want;
	} stim_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	wire                  s_tready;
	logic [IN_W-1:0]      s_tdata   = '0;
	wire                  m_tvalid;
	logic                 m_tready  = 1'b0;
	wire  [OUT_W-1:0]     m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [GAP_W-1:0]     cfg_wdata = '0;

	// own copy of the per-sender table and the burst gap register
	logic                 slot_valid [SENDERS];
	logic [SEQ_W-1:0]     slot_seq   [SENDERS];
	logic [TIME_W-1:0]    slot_orig  [SENDERS];
	logic [TIME_W-1:0]    slot_arr   [SENDERS];
	logic [GAP_W-1:0]     burst_gap  = GAP_RESET;

	verdict_t             verdict_q [$];
	int                   mismatch_count = 0;
	int                   send_idle_pct  = 0;
	int                   recv_idle_pct  = 0;
	int                   stall_cycles   = 0;

	// directed rows, all under the reset burst gap of 200 ms
	stim_row_t dir_rows [0:14] = '{
		// first message from a sender is taken whatever it holds
		'{4'd0,  32'd0,        63'd0, 63'd0,         1'b1, R_FRESH},
		// same sequence, same origin time
		'{4'd0,  32'd0,        63'd0, TMAX,          1'b1, R_DUP_TS},
		// same sequence, new origin, arrival well inside the gap
		'{4'd0,  32'd0,        63'd1, 63'd100,       1'b1, R_BURST},
		// arrival exactly one gap later: boundary of the burst check
		'{4'd0,  32'd0,        63'd1, 63'd200000000, 1'b0, R_FRESH},
		// arrival earlier than the stored one: negative difference
		'{4'd0,  32'd0,        63'd2, 63'd0,         1'b0, R_FRESH},
		// newer sequence but older origin
		'{4'd0,  32'd1,        63'd0, 63'd5,         1'b1, R_OLD_TS},
		'{4'd0,  32'd1,        63'd5, 63'd5,         1'b0, R_FRESH},
		// top slot, all fields at their maximum
		'{4'd15, SEQMAX,       TMAX,  TMAX,          1'b1, R_FRESH},
		'{4'd15, SEQMAX - 1,   TMAX,  TMAX,          1'b1, R_OLD_SEQ},
		'{4'd15, SEQMAX,       TMAX,  63'd0,         1'b1, R_DUP_TS},
		'{4'd15, SEQMAX,       63'd0, TMAX,          1'b1, R_BURST},
		'{4'd5,  32'd0,        TMAX,  63'd0,         1'b1, R_FRESH},
		'{4'd5,  32'd1,        63'd0, 63'd0,         1'b1, R_OLD_TS},
		// alternating bit patterns
		'{4'd10, 32'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555,
			1'b1, R_FRESH},
		'{4'd10, 32'hAAAA_AAAA, 63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
			1'b0, R_FRESH}
	};

	replay_freshness_filter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		// beat fields from bit 0: sender_index, sequence_req, orig_time_ns,
		// arrival_time_ns, zero fill
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		// beat fields from bit 0: accept, reason, zero fill
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	// decide one message against the table copy; a fresh one overwrites its slot
	function automatic reason_t judge_msg(msg_t m);
		logic signed [63:0] dt;
		reason_t            r;
		r = R_FRESH;
		if (slot_valid[m.idx]) begin
			// signed arrival difference, cannot overflow for 63-bit times
			dt = $signed({1'b0, m.arr}) - $signed({1'b0, slot_arr[m.idx]});
			if (m.seq < slot_seq[m.idx])
				r = R_OLD_SEQ;
			else if (m.seq == slot_seq[m.idx] && m.orig == slot_orig[m.idx])
				r = R_DUP_TS;
			else if (m.seq == slot_seq[m.idx] && dt < $signed({32'd0, burst_gap}))
				r = R_BURST;
			else if (m.orig < slot_orig[m.idx])
				r = R_OLD_TS;
		end
		if (r == R_FRESH) begin
			slot_valid[m.idx] = 1'b1;
			slot_seq[m.idx]   = m.seq;
			slot_orig[m.idx]  = m.orig;
			slot_arr[m.idx]   = m.arr;
		end
		return r;
	endfunction

	// random message: mostly follow-ups to the slot's last fresh message so the
	// later checks get exercised, the rest is unrelated noise
	function automatic msg_t make_msg();
		msg_t        m;
		int          kind;
		logic [63:0] t;
		m.idx = IDX_W'($urandom_range(0, SENDERS - 1));
		kind  = $urandom_range(0, 9);
		if (!slot_valid[m.idx] || kind >= 8) begin
			if ($urandom_range(0, 1)) begin
				m.seq  = $urandom;
				m.orig = rand_time();
				m.arr  = rand_time();
			end else begin
				m.seq  = $urandom_range(0, 1000);
				m.orig = TIME_W'($urandom_range(0, 100000));
				m.arr  = TIME_W'($urandom_range(0, 100000));
			end
			return m;
		end
		m.seq  = slot_seq[m.idx];
		m.orig = slot_orig[m.idx];
		m.arr  = slot_arr[m.idx] + TIME_W'($urandom);
		case (kind)
			0, 1, 2, 3: begin
				// newer sequence, origin moves forward or stays
				m.seq  = slot_seq[m.idx] + SEQ_W'($urandom_range(1, 3));
				m.orig = slot_orig[m.idx] + TIME_W'($urandom_range(0, 1000000));
			end
			4, 5: begin
				// repeated sequence: origin maybe identical, arrival around the gap
				m.orig = slot_orig[m.idx] + TIME_W'($urandom_range(0, 2));
				t = {1'b0, slot_arr[m.idx]} + {32'd0, burst_gap};
				t = t + 64'($urandom_range(0, 6)) - 64'd3;
				m.arr = t[TIME_W-1:0];
			end
			6: begin
				m.seq = slot_seq[m.idx] - SEQ_W'($urandom_range(1, 5));
			end
			default: begin
				// newer sequence, older origin
				m.seq  = slot_seq[m.idx] + SEQ_W'($urandom_range(1, 3));
				m.orig = slot_orig[m.idx] - TIME_W'($urandom_range(1, 100));
			end
		endcase
		return m;
	endfunction

	// present one beat, wait for its handshake, then record its verdict;
	// a typed verdict from the directed table takes the place of the prediction
	task automatic send_msg(input msg_t m, input logic typed, input reason_t want);
		int       gap_cycles;
		reason_t  r;
		verdict_t v;
		gap_cycles = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap_cycles++;
		if (gap_cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap_cycles) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'(m);
		do @(posedge clk); while (!s_tready);
		r = judge_msg(m);
		if (typed)
			r = want;
		v.accept = (r == R_FRESH);
		v.reason = r;
		verdict_q = {verdict_q, v};
	endtask

	// stop sending and hold off until every verdict is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	// new burst gap, written only with the block idle
	task automatic write_gap(input logic [GAP_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		burst_gap  = value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_random(input int count, input int s_idle, input int r_idle);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		repeat (count)
			send_msg(make_msg(), 1'b0, R_FRESH);
	endtask

	task automatic report_field(input string field, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= SHOW_MAX)
			$display("mismatch on %s: expected %0d, got %0d", field, want, got);
	endtask

	// result side: random back-pressure and the check against the oldest verdict
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_MAX)
						$display("result beat with no verdict pending: tdata %h", m_tdata);
				end else begin
					v = verdict_q.pop_front();
					if (m_tdata[0] !== v.accept)
						report_field("accept", int'(v.accept), int'(m_tdata[0]));
					if (m_tdata[3:1] !== v.reason)
						report_field("reason", int'(v.reason), int'(m_tdata[3:1]));
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog: any beat on either side counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SENDERS; i++) begin
			slot_valid[i] = 1'b0;
			slot_seq[i]   = '0;
			slot_orig[i]  = '0;
			slot_arr[i]   = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the reset gap
		send_idle_pct = 33;
		recv_idle_pct = 61;
		foreach (dir_rows[i])
			send_msg('{arr: dir_rows[i].arr, orig: dir_rows[i].orig,
				seq: dir_rows[i].seq, idx: dir_rows[i].idx},
				dir_rows[i].typed, dir_rows[i].want);

		// random phases: each gap setting starts from an idle block
		write_gap('0);
		run_random(330, 33, 61);
		write_gap({GAP_W{1'b1}});
		run_random(330, 61, 33);
		write_gap(GAP_W'($urandom));
		run_random(320, 61, 33);
		write_gap(GAP_W'($urandom_range(1, 1000)));
		run_random(320, 0, 0);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (verdict_q.size() != 0) begin
			mismatch_count++;
			$display("%0d verdicts never came back", verdict_q.size());
		end
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
